[sv/preferred_address_parser_top_macros.svh]
// assertion macros for the preferred address parser
`ifndef PREFERRED_ADDRESS_PARSER_TOP_MACROS_SVH
`define PREFERRED_ADDRESS_PARSER_TOP_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define PAP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define PAP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/pap_pkg.sv]
// shared widths, field codes, status codes and result type of the parser
package pap_pkg;

   localparam int BYTE_W     = 8;
   localparam int TAG_W      = 4;
   localparam int INDEX_W    = 5;
   localparam int STATUS_W   = 3;
   localparam int CONSUMED_W = 7;
   localparam int VARINT_W   = 62;
   localparam int VALUE_W    = 7;
   localparam int HDR_CNT_W  = 5;

   localparam int MAX_CID_LEN_DEFAULT = 20;
   localparam logic [VARINT_W-1:0] PARAM_ID_RESET = 62'd13;

   // value layout: ipv4(4) port(2) ipv6(16) port(2) cid length(1) cid token(16)
   localparam int IPV4_END       = 4;
   localparam int IPV4_PORT_END  = 6;
   localparam int IPV6_END       = 22;
   localparam int IPV6_PORT_END  = 24;
   localparam int CID_LEN_POS    = 24;
   localparam int CID_START      = 25;
   localparam int TOKEN_LEN      = 16;
   localparam int VALUE_FIXED    = 41;

   localparam logic [TAG_W-1:0] TAG_HEADER    = 4'd0;
   localparam logic [TAG_W-1:0] TAG_IPV4      = 4'd1;
   localparam logic [TAG_W-1:0] TAG_IPV4_PORT = 4'd2;
   localparam logic [TAG_W-1:0] TAG_IPV6      = 4'd3;
   localparam logic [TAG_W-1:0] TAG_IPV6_PORT = 4'd4;
   localparam logic [TAG_W-1:0] TAG_CID_LEN   = 4'd5;
   localparam logic [TAG_W-1:0] TAG_CID       = 4'd6;
   localparam logic [TAG_W-1:0] TAG_TOKEN     = 4'd7;
   localparam logic [TAG_W-1:0] TAG_IGNORED   = 4'd8;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_TRUNCATED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_WRONG_ID  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_CID_LONG  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_LEN_BAD   = 3'd4;

   typedef struct packed {
      logic [BYTE_W-1:0]     echo_byte;
      logic [TAG_W-1:0]      field_tag;
      logic [INDEX_W-1:0]    field_index;
      logic                  at_end;
      logic [STATUS_W-1:0]   status;
      logic [CONSUMED_W-1:0] consumed_length;
   } rsp_item_type;

endpackage

[sv/pap_req_if.sv]
// input byte channel of the parser
interface pap_req_if
   import pap_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              last;

   modport source (output valid, output data_byte, output last, input ready);
   modport sink (input valid, input data_byte, input last, output ready);
endinterface

[sv/pap_rsp_if.sv]
// result channel of the parser
interface pap_rsp_if
   import pap_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [BYTE_W-1:0]     echo_byte;
   logic [TAG_W-1:0]      field_tag;
   logic [INDEX_W-1:0]    field_index;
   logic                  at_end;
   logic [STATUS_W-1:0]   status;
   logic [CONSUMED_W-1:0] consumed_length;

   modport source (output valid, output echo_byte, output field_tag, output field_index,
                   output at_end, output status, output consumed_length, input ready);
   modport sink (input valid, input echo_byte, input field_tag, input field_index,
                 input at_end, input status, input consumed_length, output ready);
endinterface

[sv/pap_csr_if.sv]
// register write channel of the parser
interface pap_csr_if
   import pap_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [VARINT_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[sv/preferred_address_parser_top.sv]
// preferred address transport parameter parser, one byte per item
//
// req_bus carries one buffer byte per item with a last flag. the block
// decodes the id and length varints, then tags every value byte with its
// field and big-endian index. each item gives exactly one result on rsp_bus;
// the result for the last byte also carries status and consumed length.
// csr_bus writes the expected parameter id (reset value 13), always ready;
// write it only while no item is in flight.
// the result for each accepted byte is registered; one byte is taken per
// cycle while the output stage has room, set by the per-byte state update in a
// single pass between the parse state registers and the result register.
// a two-entry output stage (result register plus skid) lets the block take
// one more item while the receiver stalls; req_bus.ready drops once both
// entries are full and rises again as soon as one is taken.
// reset (synchronous, active high) empties the output stage and returns the
// parser to the start of a buffer. after every last byte the parser also
// returns to the start, keeping the expected id.
module preferred_address_parser_top
   import pap_pkg::*;
   #(
      parameter int MAX_CID_LEN = MAX_CID_LEN_DEFAULT
   ) (
      input  logic   clock,
      input  logic   reset,
      pap_req_if.sink   req_bus,
      pap_rsp_if.source rsp_bus,
      pap_csr_if.sink   csr_bus
   );

`include "preferred_address_parser_top_macros.svh"

   localparam int CID_W = $clog2(MAX_CID_LEN + 1);
   localparam logic [VARINT_W-1:0] LEN_LIMIT = VARINT_W'(VALUE_FIXED + MAX_CID_LEN);

   localparam logic [1:0] PH_ID    = 2'd0;
   localparam logic [1:0] PH_LEN   = 2'd1;
   localparam logic [1:0] PH_VALUE = 2'd2;
   localparam logic [1:0] PH_DONE  = 2'd3;

   logic [VARINT_W-1:0]  expected_id_ff;
   logic [1:0]           phase_ff, phase_in;
   logic [VARINT_W-1:0]  accum_ff, accum_in;
   logic [2:0]           bytes_left_ff, bytes_left_in;
   logic                 id_mismatch_ff, id_mismatch_in;
   logic [VALUE_W-1:0]   value_length_ff, value_length_in;
   logic [HDR_CNT_W-1:0] header_count_ff, header_count_in;
   logic [VALUE_W-1:0]   value_count_ff, value_count_in;
   logic [CID_W-1:0]     cid_length_ff, cid_length_in;
   logic [STATUS_W-1:0]  error_ff, error_in;

   rsp_item_type rsp_ff, rsp_in, skid_ff, skid_in;
   logic         rsp_valid_ff, rsp_valid_in, skid_valid_ff, skid_valid_in;
   rsp_item_type item;

   logic                 req_fire;
   logic [VARINT_W-1:0]  accum_v;
   logic [2:0]           left_v;
   logic [VALUE_W-1:0]   pos;
   logic [VALUE_W-1:0]   cid_off;
   logic [VALUE_W-1:0]   tok_off;

   assign req_bus.ready = !skid_valid_ff;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   always_comb begin
      phase_in        = phase_ff;
      accum_in        = accum_ff;
      bytes_left_in   = bytes_left_ff;
      id_mismatch_in  = id_mismatch_ff;
      value_length_in = value_length_ff;
      header_count_in = header_count_ff;
      value_count_in  = value_count_ff;
      cid_length_in   = cid_length_ff;
      error_in        = error_ff;
      accum_v         = accum_ff;
      left_v          = bytes_left_ff;
      pos             = value_count_ff;
      cid_off         = pos - VALUE_W'(CID_START);
      tok_off         = cid_off - VALUE_W'(cid_length_ff);

      item.echo_byte       = req_bus.data_byte;
      item.field_tag       = TAG_IGNORED;
      item.field_index     = '0;
      item.at_end          = req_bus.last;
      item.status          = ST_OK;
      item.consumed_length = '0;

      unique case (phase_ff)
         PH_ID, PH_LEN: begin
            item.field_tag   = TAG_HEADER;
            item.field_index = INDEX_W'(header_count_ff);
            header_count_in  = header_count_ff + HDR_CNT_W'(1);
            if (bytes_left_ff == 3'd0) begin
               // first varint byte: top two bits select 1, 2, 4 or 8 bytes
               accum_v = {{(VARINT_W-6){1'b0}}, req_bus.data_byte[5:0]};
               unique case (req_bus.data_byte[7:6])
                  2'b00: left_v = 3'd0;
                  2'b01: left_v = 3'd1;
                  2'b10: left_v = 3'd3;
                  2'b11: left_v = 3'd7;
               endcase
            end else begin
               accum_v = {accum_ff[VARINT_W-9:0], req_bus.data_byte};
               left_v  = bytes_left_ff - 3'd1;
            end
            accum_in      = accum_v;
            bytes_left_in = left_v;
            if (left_v == 3'd0) begin
               if (phase_ff == PH_ID) begin
                  id_mismatch_in = accum_v != expected_id_ff;
                  phase_in       = PH_LEN;
               end else if (accum_v > LEN_LIMIT) begin
                  error_in = ST_LEN_BAD;
                  phase_in = PH_DONE;
               end else begin
                  value_length_in = accum_v[VALUE_W-1:0];
                  phase_in = (accum_v[VALUE_W-1:0] == '0) ? PH_DONE : PH_VALUE;
               end
            end
         end
         PH_VALUE: begin
            value_count_in = value_count_ff + VALUE_W'(1);
            if (value_count_in >= value_length_ff) begin
               phase_in = PH_DONE;
            end
            priority if (pos < VALUE_W'(IPV4_END)) begin
               item.field_tag   = TAG_IPV4;
               item.field_index = INDEX_W'(pos);
            end else if (pos < VALUE_W'(IPV4_PORT_END)) begin
               item.field_tag   = TAG_IPV4_PORT;
               item.field_index = INDEX_W'(pos - VALUE_W'(IPV4_END));
            end else if (pos < VALUE_W'(IPV6_END)) begin
               item.field_tag   = TAG_IPV6;
               item.field_index = INDEX_W'(pos - VALUE_W'(IPV4_PORT_END));
            end else if (pos < VALUE_W'(IPV6_PORT_END)) begin
               item.field_tag   = TAG_IPV6_PORT;
               item.field_index = INDEX_W'(pos - VALUE_W'(IPV6_END));
            end else if (pos == VALUE_W'(CID_LEN_POS)) begin
               item.field_tag = TAG_CID_LEN;
               if (req_bus.data_byte > BYTE_W'(MAX_CID_LEN)) begin
                  error_in      = ST_CID_LONG;
                  cid_length_in = '0;
               end else begin
                  cid_length_in = CID_W'(req_bus.data_byte);
               end
            end else if (error_ff == ST_CID_LONG) begin
               item.field_tag = TAG_IGNORED;
            end else if (cid_off < VALUE_W'(cid_length_ff)) begin
               item.field_tag   = TAG_CID;
               item.field_index = INDEX_W'(cid_off);
            end else if (tok_off < VALUE_W'(TOKEN_LEN)) begin
               item.field_tag   = TAG_TOKEN;
               item.field_index = INDEX_W'(tok_off);
            end else begin
               item.field_tag = TAG_IGNORED;
            end
         end
         PH_DONE: begin
            item.field_tag = TAG_IGNORED;
         end
      endcase

      if (req_bus.last) begin
         priority if (phase_in != PH_DONE) begin
            item.status = ST_TRUNCATED;
         end else if (error_in == ST_LEN_BAD) begin
            item.status = ST_LEN_BAD;
         end else if (id_mismatch_in) begin
            item.status = ST_WRONG_ID;
         end else if (error_in == ST_CID_LONG) begin
            item.status = ST_CID_LONG;
         end else if (value_length_in < VALUE_W'(CID_START) ||
                      value_length_in != VALUE_W'(VALUE_FIXED) + VALUE_W'(cid_length_in)) begin
            item.status = ST_LEN_BAD;
         end else begin
            item.consumed_length = CONSUMED_W'(header_count_in) + CONSUMED_W'(value_length_in);
         end
         // next byte starts a new buffer
         phase_in        = PH_ID;
         accum_in        = '0;
         bytes_left_in   = '0;
         id_mismatch_in  = 1'b0;
         value_length_in = '0;
         header_count_in = '0;
         value_count_in  = '0;
         cid_length_in   = '0;
         error_in        = ST_OK;
      end
   end

   // result register with one skid entry behind it
   always_comb begin
      rsp_in        = rsp_ff;
      skid_in       = skid_ff;
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (!rsp_valid_ff || rsp_bus.ready) begin
         if (skid_valid_ff) begin
            rsp_in        = skid_ff;
            rsp_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (req_fire) begin
            rsp_in       = item;
            rsp_valid_in = 1'b1;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end else if (req_fire) begin
         skid_in       = item;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_id_ff  <= PARAM_ID_RESET;
         phase_ff        <= PH_ID;
         accum_ff        <= '0;
         bytes_left_ff   <= '0;
         id_mismatch_ff  <= 1'b0;
         value_length_ff <= '0;
         header_count_ff <= '0;
         value_count_ff  <= '0;
         cid_length_ff   <= '0;
         error_ff        <= ST_OK;
         rsp_valid_ff    <= 1'b0;
         skid_valid_ff   <= 1'b0;
      end else begin
         if (csr_bus.valid) begin
            expected_id_ff <= csr_bus.data;
         end
         if (req_fire) begin
            phase_ff        <= phase_in;
            accum_ff        <= accum_in;
            bytes_left_ff   <= bytes_left_in;
            id_mismatch_ff  <= id_mismatch_in;
            value_length_ff <= value_length_in;
            header_count_ff <= header_count_in;
            value_count_ff  <= value_count_in;
            cid_length_ff   <= cid_length_in;
            error_ff        <= error_in;
         end
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.echo_byte       = rsp_ff.echo_byte;
   assign rsp_bus.field_tag       = rsp_ff.field_tag;
   assign rsp_bus.field_index     = rsp_ff.field_index;
   assign rsp_bus.at_end          = rsp_ff.at_end;
   assign rsp_bus.status          = rsp_ff.status;
   assign rsp_bus.consumed_length = rsp_ff.consumed_length;

   `PAP_ASSERT_NOW(a_skid_behind_rsp, skid_valid_ff, rsp_valid_ff, "skid full with empty result")
   `PAP_ASSERT_NOW(a_mid_quiet, rsp_valid_ff && !rsp_ff.at_end,
                   rsp_ff.status == ST_OK && rsp_ff.consumed_length == '0,
                   "status or length reported before the last byte")
   `PAP_ASSERT_NOW(a_fail_no_len, rsp_valid_ff && rsp_ff.status != ST_OK,
                   rsp_ff.consumed_length == '0, "consumed length on a failed parse")
   `PAP_ASSERT_NEXT(a_restart, req_fire && req_bus.last,
                    phase_ff == PH_ID && bytes_left_ff == 3'd0 && header_count_ff == '0,
                    "parser not back at buffer start after last byte")

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// testbench for the preferred address parser: byte stream driver, result checker, own parse model
module tb;
   import pap_pkg::*;

   localparam int MAX_CID          = MAX_CID_LEN_DEFAULT;
   localparam int BYTES_PER_PHASE  = 150;
   localparam int HOLD_CYCLES      = 400;
   localparam int TIMEOUT_NS       = 10_000_000;

   typedef enum logic [1:0] {SCAN_ID, SCAN_LEN, SCAN_VALUE, SCAN_DONE} scan_phase_type;
   typedef enum {FR_GOOD, FR_TRUNC, FR_WRONG_ID, FR_CID_LONG, FR_LEN_BAD, FR_LEN_HUGE,
                 FR_NOISE} frame_kind_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } req_item_type;

   logic clock;
   logic reset;

   pap_req_if req_bus();
   pap_rsp_if rsp_bus();
   pap_csr_if csr_bus();

   preferred_address_parser_top #(.MAX_CID_LEN(MAX_CID)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // parse model state
   scan_phase_type     scan_ph;
   logic [VARINT_W-1:0] acc;
   int                 acc_left;
   logic               acc_busy;
   logic               id_wrong;
   logic               len_too_big;
   logic               cid_too_long;
   int                 val_len;
   int                 hdr_cnt;
   int                 val_cnt;
   int                 cid_len;
   logic [VARINT_W-1:0] want_param_id;

   req_item_type pending[$];
   rsp_item_type expected_rsp[$];
   logic [BYTE_W-1:0] frame_bytes[$];

   int   queued_total = 0;
   int   accepted_cnt = 0;
   int   fail_cnt = 0;
   int   req_gap_pct = 30;
   int   rsp_stall_pct = 30;
   int   gap_left = 0;
   int   stall_left = 0;
   logic hold_off = 1'b0;
   req_item_type next_item;
   rsp_item_type got_rsp;
   rsp_item_type want_rsp;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void reset_parse();
      scan_ph      = SCAN_ID;
      acc          = '0;
      acc_left     = 0;
      acc_busy     = 1'b0;
      id_wrong     = 1'b0;
      len_too_big  = 1'b0;
      cid_too_long = 1'b0;
      val_len      = 0;
      hdr_cnt      = 0;
      val_cnt      = 0;
      cid_len      = 0;
   endfunction

   function automatic rsp_item_type parse_byte(input logic [BYTE_W-1:0] b, input logic end_flag);
      rsp_item_type r;
      int p;
      int q;
      r.echo_byte       = b;
      r.field_tag       = TAG_IGNORED;
      r.field_index     = '0;
      r.at_end          = end_flag;
      r.status          = ST_OK;
      r.consumed_length = '0;
      if (scan_ph == SCAN_ID || scan_ph == SCAN_LEN) begin
         r.field_tag   = TAG_HEADER;
         r.field_index = INDEX_W'(hdr_cnt);
         hdr_cnt++;
         if (!acc_busy) begin
            // top two bits give the varint size
            acc      = {56'd0, b[5:0]};
            acc_left = (1 << b[7:6]) - 1;
            acc_busy = 1'b1;
         end else begin
            acc      = {acc[53:0], b};
            acc_left--;
         end
         if (acc_left == 0) begin
            acc_busy = 1'b0;
            if (scan_ph == SCAN_ID) begin
               id_wrong = (acc != want_param_id);
               scan_ph  = SCAN_LEN;
            end else if (acc > VARINT_W'(VALUE_FIXED + MAX_CID)) begin
               len_too_big = 1'b1;
               scan_ph     = SCAN_DONE;
            end else begin
               val_len = int'(acc);
               scan_ph = (val_len == 0) ? SCAN_DONE : SCAN_VALUE;
            end
         end
      end else if (scan_ph == SCAN_VALUE) begin
         p = val_cnt;
         if (p < IPV4_END) begin
            r.field_tag   = TAG_IPV4;
            r.field_index = INDEX_W'(p);
         end else if (p < IPV4_PORT_END) begin
            r.field_tag   = TAG_IPV4_PORT;
            r.field_index = INDEX_W'(p - IPV4_END);
         end else if (p < IPV6_END) begin
            r.field_tag   = TAG_IPV6;
            r.field_index = INDEX_W'(p - IPV4_PORT_END);
         end else if (p < IPV6_PORT_END) begin
            r.field_tag   = TAG_IPV6_PORT;
            r.field_index = INDEX_W'(p - IPV6_END);
         end else if (p == CID_LEN_POS) begin
            r.field_tag = TAG_CID_LEN;
            if (b > MAX_CID) begin
               cid_too_long = 1'b1;
               cid_len      = 0;
            end else begin
               cid_len = int'(b);
            end
         end else if (!cid_too_long) begin
            q = p - CID_START;
            if (q < cid_len) begin
               r.field_tag   = TAG_CID;
               r.field_index = INDEX_W'(q);
            end else if (q - cid_len < TOKEN_LEN) begin
               r.field_tag   = TAG_TOKEN;
               r.field_index = INDEX_W'(q - cid_len);
            end
         end
         val_cnt++;
         if (val_cnt >= val_len) scan_ph = SCAN_DONE;
      end
      if (end_flag) begin
         if (scan_ph != SCAN_DONE) begin
            r.status = ST_TRUNCATED;
         end else if (len_too_big) begin
            r.status = ST_LEN_BAD;
         end else if (id_wrong) begin
            r.status = ST_WRONG_ID;
         end else if (cid_too_long) begin
            r.status = ST_CID_LONG;
         end else if (val_len < CID_START || val_len != VALUE_FIXED + cid_len) begin
            r.status = ST_LEN_BAD;
         end else begin
            r.consumed_length = CONSUMED_W'(hdr_cnt + val_len);
         end
         reset_parse();
      end
      return r;
   endfunction

   function automatic int pick_gap(input int pct);
      if ($urandom_range(99) >= pct) return 0;
      if ($urandom_range(9) == 0) return $urandom_range(40, 10);
      return $urandom_range(3, 1);
   endfunction

   function automatic logic [VARINT_W-1:0] rand62();
      logic [63:0] r;
      r = {$urandom(), $urandom()};
      return r[VARINT_W-1:0];
   endfunction

   // smallest size that holds v, sometimes widened to a longer encoding
   function automatic int varint_size(input logic [VARINT_W-1:0] v);
      int n;
      if (v < 64) n = 1;
      else if (v < (1 << 14)) n = 2;
      else if (v < (62'd1 << 30)) n = 4;
      else n = 8;
      while (n < 8 && $urandom_range(3) == 0) n = n * 2;
      return n;
   endfunction

   task automatic put_varint(input logic [VARINT_W-1:0] v, input int n);
      logic [63:0] word;
      int sel;
      int i;
      sel  = (n == 1) ? 0 : (n == 2) ? 1 : (n == 4) ? 2 : 3;
      word = {2'b00, v} | (64'(sel) << (8 * n - 2));
      for (i = n - 1; i >= 0; i--) frame_bytes.push_back(word[8*i +: 8]);
   endtask

   task automatic emit_frame(input int cut);
      req_item_type it;
      int i;
      for (i = 0; i < cut; i++) begin
         it.data = frame_bytes[i];
         it.last = (i == cut - 1);
         pending.push_back(it);
      end
      queued_total += cut;
   endtask

   task automatic queue_frame(input frame_kind_type kind);
      logic [VARINT_W-1:0] id;
      logic [VARINT_W-1:0] len_val;
      logic [VARINT_W-1:0] flip;
      logic [BYTE_W-1:0]   cid_byte;
      int cid_n;
      int vlen;
      int cut;
      int p;
      frame_bytes.delete();
      if (kind == FR_NOISE) begin
         repeat ($urandom_range(6, 1)) frame_bytes.push_back(8'($urandom_range(255)));
         emit_frame(frame_bytes.size());
         return;
      end
      id = want_param_id;
      if (kind == FR_WRONG_ID) begin
         flip = $urandom_range(1) ? (62'd1 << $urandom_range(61)) : rand62();
         if (flip == '0) flip = 62'd1;
         id = id ^ flip;
      end
      cid_n    = $urandom_range(MAX_CID);
      cid_byte = 8'(cid_n);
      vlen     = VALUE_FIXED + cid_n;
      len_val  = VARINT_W'(vlen);
      case (kind)
         FR_CID_LONG: begin
            cid_byte = 8'($urandom_range(255, MAX_CID + 1));
            vlen     = $urandom_range(VALUE_FIXED + MAX_CID, CID_START);
            len_val  = VARINT_W'(vlen);
         end
         FR_LEN_BAD: begin
            vlen = $urandom_range(VALUE_FIXED + MAX_CID);
            if (vlen == VALUE_FIXED + cid_n) vlen = $urandom_range(CID_LEN_POS);
            len_val = VARINT_W'(vlen);
         end
         FR_LEN_HUGE: begin
            len_val = $urandom_range(1) ? VARINT_W'(VALUE_FIXED + MAX_CID + 1 + $urandom_range(2))
                                        : (rand62() | 62'd64);
            vlen    = $urandom_range(12);
         end
         default: ;
      endcase
      put_varint(id, varint_size(id));
      put_varint(len_val, varint_size(len_val));
      for (p = 0; p < vlen; p++)
         frame_bytes.push_back((p == CID_LEN_POS) ? cid_byte : 8'($urandom_range(255)));
      if (kind == FR_TRUNC) begin
         cut = $urandom_range(frame_bytes.size() - 1, 1);
      end else begin
         if ($urandom_range(9) < 3)
            repeat ($urandom_range(6, 1)) frame_bytes.push_back(8'($urandom_range(255)));
         cut = frame_bytes.size();
      end
      emit_frame(cut);
   endtask

   task automatic drain();
      while (pending.size() != 0 || req_bus.valid || expected_rsp.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // byte driver: predicts each accepted item, then offers the next one
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_rsp.push_back(parse_byte(req_bus.data_byte, req_bus.last));
            accepted_cnt++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (pending.size() != 0) begin
               next_item = pending.pop_front();
               req_bus.valid     <= 1'b1;
               req_bus.data_byte <= next_item.data;
               req_bus.last      <= next_item.last;
               gap_left = pick_gap(req_gap_pct);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   task automatic cmp_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_cnt++;
      end
   endtask

   // result monitor with random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got_rsp.echo_byte       = rsp_bus.echo_byte;
            got_rsp.field_tag       = rsp_bus.field_tag;
            got_rsp.field_index     = rsp_bus.field_index;
            got_rsp.at_end          = rsp_bus.at_end;
            got_rsp.status          = rsp_bus.status;
            got_rsp.consumed_length = rsp_bus.consumed_length;
            if (expected_rsp.size() == 0) begin
               $error("result with no item pending: echo_byte %0d", got_rsp.echo_byte);
               fail_cnt++;
            end else begin
               want_rsp = expected_rsp.pop_front();
               cmp_field("echo_byte", want_rsp.echo_byte, got_rsp.echo_byte);
               cmp_field("field_tag", 8'(want_rsp.field_tag), 8'(got_rsp.field_tag));
               cmp_field("field_index", 8'(want_rsp.field_index), 8'(got_rsp.field_index));
               cmp_field("at_end", 8'(want_rsp.at_end), 8'(got_rsp.at_end));
               cmp_field("status", 8'(want_rsp.status), 8'(got_rsp.status));
               cmp_field("consumed_length", 8'(want_rsp.consumed_length),
                         8'(got_rsp.consumed_length));
            end
         end
         if (hold_off) begin
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            stall_left = pick_gap(rsp_stall_pct);
         end
      end
   end

   // long receiver hold-offs so the output stage fills and the input stalls
   initial begin : rsp_hold
      int k;
      for (k = 0; k < 2; k++) begin
         while (accepted_cnt < 200 + 300 * k) @(posedge clock);
         hold_off <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_off <= 1'b0;
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : stimulus
      int ph;
      int target;
      int roll;
      frame_kind_type kind;
      logic [VARINT_W-1:0] id_val;

      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.data_byte = '0;
      req_bus.last      = 1'b0;
      rsp_bus.ready     = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.data      = '0;
      want_param_id     = PARAM_ID_RESET;
      reset_parse();

      // short buffers for the corner cases, under the reset id
      frame_bytes = '{8'h00};
      emit_frame(1);                                       // ends after the id, before the length
      frame_bytes = '{8'hFF};
      emit_frame(1);                                       // ends inside an 8-byte id
      frame_bytes = '{8'h0D, 8'h00};
      emit_frame(2);                                       // empty value
      frame_bytes = '{8'h0D, 8'h3E, 8'h11, 8'h22};
      emit_frame(4);                                       // length one past the limit
      frame_bytes = '{8'h0E, 8'h00};
      emit_frame(2);                                       // wrong id
      frame_bytes = '{8'h40, 8'h0D, 8'h01, 8'hAB};
      emit_frame(4);                                       // value too short
      frame_bytes = '{8'h0D, 8'h19, 8'h01};
      emit_frame(3);                                       // ends inside the value

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (ph = 0; ph < 5; ph++) begin
         if (ph != 0) begin
            drain();
            case (ph)
               1: id_val = '1;
               2: id_val = '0;
               3: id_val = rand62();
               default: id_val = VARINT_W'($urandom_range(63));
            endcase
            @(posedge clock);
            csr_bus.valid <= 1'b1;
            csr_bus.data  <= id_val;
            do @(posedge clock); while (!csr_bus.ready);
            csr_bus.valid <= 1'b0;
            want_param_id = id_val;
            case (ph)
               1: begin req_gap_pct <= 0;  rsp_stall_pct <= 0;  end
               2: begin req_gap_pct <= 60; rsp_stall_pct <= 40; end
               3: begin req_gap_pct <= 20; rsp_stall_pct <= 60; end
               default: begin req_gap_pct <= 45; rsp_stall_pct <= 15; end
            endcase
         end
         target = queued_total + BYTES_PER_PHASE;
         while (queued_total < target) begin
            roll = $urandom_range(99);
            if (roll < 55) kind = FR_GOOD;
            else if (roll < 65) kind = FR_TRUNC;
            else if (roll < 73) kind = FR_WRONG_ID;
            else if (roll < 81) kind = FR_CID_LONG;
            else if (roll < 89) kind = FR_LEN_BAD;
            else if (roll < 94) kind = FR_LEN_HUGE;
            else kind = FR_NOISE;
            queue_frame(kind);
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (fail_cnt == 0 && expected_rsp.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
